@@ hw/rtl/fpfir_pkg.sv @@
package fpfir_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int DL_W       = 12;
	localparam int COEFF_W    = 16;
	localparam int PROD_W     = COEFF_W + DL_W;
	localparam int IDX_W      = 5;
	localparam int IN_SHIFT   = 4;
	localparam int FRAC_SHIFT = 15;
	localparam int OUT_W      = 16;

	localparam logic MODE_FILTER = 1'b0;
	localparam logic MODE_COEFF  = 1'b1;

	typedef struct packed {
		logic shift;
		logic advance;
	} cell_ctl_t;

endpackage

@@ hw/rtl/fixed_point_fir_filter_unit.sv @@
// A sample transfer shifts the delay line; its partial sum then walks the tap chain one
// cell per cycle unless held by a full output, and the result is registered. No new item
// is taken until that sum leaves the chain; a coefficient transfer leaves it ready.
// A finished result may wait in the output register while the next item is taken.
// Reset (arst_n low, asynchronous) clears the delay line, the coefficients and
// all handshake state; the block is ready straight after reset.
module fixed_point_fir_filter_unit #(
	parameter int TAPS = 32
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic                                   mode,
	input  logic signed [fpfir_pkg::SAMPLE_W-1:0]  sample_in,
	input  logic [fpfir_pkg::IDX_W-1:0]            coeff_index,
	input  logic signed [fpfir_pkg::COEFF_W-1:0]   coeff_value,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [fpfir_pkg::OUT_W-1:0]     sample_out,
	output logic                                   overflow
);

	localparam int ACC_RAW = fpfir_pkg::PROD_W + $clog2(TAPS) + 1;
	localparam int ACC_W   = (ACC_RAW > 32) ? ACC_RAW : 32;
	localparam int OVF_LO  = fpfir_pkg::FRAC_SHIFT + fpfir_pkg::OUT_W - 1;

	logic                          busy_q;
	logic                          launch_s1;
	logic                          launch_s2;
	logic                          out_valid_q;
	logic signed [fpfir_pkg::OUT_W-1:0] sample_out_q;
	logic                          overflow_q;

	logic                          in_xfer;
	logic                          sample_xfer;
	logic                          coeff_xfer;
	logic                          stall;
	logic                          finish;
	fpfir_pkg::cell_ctl_t          ctl;

	logic signed [fpfir_pkg::DL_W-1:0] smp [TAPS];
	logic signed [ACC_W-1:0]           acc [TAPS];
	logic [TAPS-1:0]                   vld;
	logic [ACC_W-1:OVF_LO]             acc_top;

	assign in_ready    = !busy_q;
	assign in_xfer     = in_valid && in_ready;
	assign sample_xfer = in_xfer && (mode == fpfir_pkg::MODE_FILTER);
	assign coeff_xfer  = in_xfer && (mode == fpfir_pkg::MODE_COEFF)
	                     && (32'(coeff_index) < TAPS);

	assign stall  = vld[TAPS-1] && out_valid_q && !out_ready;
	assign finish = vld[TAPS-1] && !stall;

	assign ctl.shift   = sample_xfer;
	assign ctl.advance = !stall;

	genvar k;
	generate
		for (k = 0; k < TAPS; k++) begin : g_tap
			logic signed [fpfir_pkg::DL_W-1:0] prev;
			logic signed [ACC_W-1:0]           a_in;
			logic                              v_in;

			if (k == 0) begin : g_head
				assign prev = sample_in[fpfir_pkg::SAMPLE_W-1:fpfir_pkg::IN_SHIFT];
				assign a_in = '0;
				assign v_in = launch_s2;
			end else begin : g_body
				assign prev = smp[k-1];
				assign a_in = acc[k-1];
				assign v_in = vld[k-1];
			end

			fpfir_cell #(
				.ACC_W(ACC_W)
			) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctl        (ctl),
				.coeff_we   (coeff_xfer && (32'(coeff_index) == k)),
				.coeff_value(coeff_value),
				.sample_prev(prev),
				.sample_q   (smp[k]),
				.acc_in     (a_in),
				.vld_in     (v_in),
				.acc_q      (acc[k]),
				.vld_q      (vld[k])
			);
		end
	endgenerate

	// launch passes through launch_s1 and launch_s2: shift, then products settle in every cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			launch_s1 <= 1'b0;
			launch_s2 <= 1'b0;
		end else begin
			launch_s1 <= sample_xfer;
			launch_s2 <= launch_s1;
			if (sample_xfer) begin
				busy_q <= 1'b1;
			end else if (finish) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign acc_top = acc[TAPS-1][ACC_W-1:OVF_LO];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			sample_out_q <= acc[TAPS-1][OVF_LO:fpfir_pkg::FRAC_SHIFT];
			overflow_q   <= !((&acc_top) || !(|acc_top));
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;
	assign overflow   = overflow_q;

`ifndef NO_ASSERTIONS
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({launch_s1, launch_s2, vld}))
		else $error("more than one partial sum in the tap chain");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> !(launch_s1 || launch_s2 || (|vld)))
		else $error("partial sum in flight while idle");

	a_busy_after_sample: assert property (@(posedge clk) disable iff (!arst_n)
		sample_xfer |=> busy_q && launch_s1)
		else $error("sample transfer did not start a sum");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		stall |=> vld[TAPS-1] && out_valid_q)
		else $error("finished sum lost while output was full");

	a_finish_frees: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> !busy_q && out_valid_q)
		else $error("result hand-off did not release the chain");
`endif

endmodule

@@ hw/rtl/fpfir_cell.sv @@
module fpfir_cell #(
	parameter int ACC_W = 32
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  fpfir_pkg::cell_ctl_t                      ctl,
	input  logic                                      coeff_we,
	input  logic signed [fpfir_pkg::COEFF_W-1:0]      coeff_value,
	input  logic signed [fpfir_pkg::DL_W-1:0]         sample_prev,
	output logic signed [fpfir_pkg::DL_W-1:0]         sample_q,
	input  logic signed [ACC_W-1:0]                   acc_in,
	input  logic                                      vld_in,
	output logic signed [ACC_W-1:0]                   acc_q,
	output logic                                      vld_q
);

	logic signed [fpfir_pkg::COEFF_W-1:0] coeff_q;
	logic signed [fpfir_pkg::PROD_W-1:0]  prod_d;
	logic signed [fpfir_pkg::PROD_W-1:0]  prod_q;

	assign prod_d = coeff_q * sample_q;

	// tap state: one delay-line entry and its coefficient
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coeff_q  <= '0;
			sample_q <= '0;
		end else begin
			if (coeff_we) begin
				coeff_q <= coeff_value;
			end
			if (ctl.shift) begin
				sample_q <= sample_prev;
			end
		end
	end

	// product is refreshed every cycle; line is frozen while a sum is in flight
	always_ff @(posedge clk) begin
		prod_q <= prod_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctl.advance) begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.advance) begin
			acc_q <= acc_in + ACC_W'(prod_q);
		end
	end

endmodule

@@ bench/fir_output_checker.sv @@
`timescale 1ns / 100ps

module fir_output_checker #(
	parameter int TAPS = 32
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	input  logic                                   in_ready,
	input  logic                                   mode,
	input  logic signed [fpfir_pkg::SAMPLE_W-1:0]  sample_in,
	input  logic [fpfir_pkg::IDX_W-1:0]            coeff_index,
	input  logic signed [fpfir_pkg::COEFF_W-1:0]   coeff_value,
	input  logic                                   out_valid,
	input  logic                                   out_ready,
	input  logic signed [fpfir_pkg::OUT_W-1:0]     sample_out,
	input  logic                                   overflow,
	output int unsigned                            failures,
	output int unsigned                            pending
);

	typedef struct packed {
		logic signed [fpfir_pkg::OUT_W-1:0] value;
		logic                               ovf;
	} fir_out_t;

	// sample_out is bits 30:15 of the sum, so anything outside +-2^30 is lost
	localparam longint ACC_LIMIT =
		longint'(1) <<< (fpfir_pkg::FRAC_SHIFT + fpfir_pkg::OUT_W - 1);

	logic signed [fpfir_pkg::COEFF_W-1:0] tap_coeff [TAPS];
	logic signed [fpfir_pkg::DL_W-1:0]    tap_delay [TAPS];
	int                                   head;
	fir_out_t                             filtered_q [$];
	int unsigned                          fail_count = 0;
	int unsigned                          result_count = 0;
	int unsigned                          backlog = 0;

	assign failures = fail_count;
	assign pending  = backlog;

	function automatic fir_out_t filter_next_sample(
			input logic signed [fpfir_pkg::SAMPLE_W-1:0] s);
		longint   acc;
		int       j;
		fir_out_t r;
		tap_delay[head] = fpfir_pkg::DL_W'(s >>> fpfir_pkg::IN_SHIFT);
		acc = 0;
		for (int k = 0; k < TAPS; k++) begin
			j = (head + TAPS - k) % TAPS;
			acc += longint'(tap_coeff[k]) * longint'(tap_delay[j]);
		end
		head = (head + 1) % TAPS;
		r.value = acc[fpfir_pkg::FRAC_SHIFT + fpfir_pkg::OUT_W - 1:fpfir_pkg::FRAC_SHIFT];
		r.ovf   = (acc < -ACC_LIMIT) || (acc > ACC_LIMIT - 1);
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t: %s", $time, msg);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		fir_out_t want;
		if (!arst_n) begin
			for (int k = 0; k < TAPS; k++) begin
				tap_coeff[k] = '0;
				tap_delay[k] = '0;
			end
			head = 0;
			filtered_q.delete();
			backlog = 0;
		end else begin
			// result side first: a result leaving now cannot belong to a sample arriving now
			if (out_valid && out_ready) begin
				result_count++;
				if (filtered_q.size() == 0) begin
					report_mismatch($sformatf("result %0d unexpected: sample_out %0d overflow %0b",
						result_count, sample_out, overflow));
				end else begin
					want = filtered_q.pop_front();
					if (sample_out !== want.value)
						report_mismatch($sformatf("result %0d: sample_out %0d, expected %0d",
							result_count, sample_out, want.value));
					if (overflow !== want.ovf)
						report_mismatch($sformatf("result %0d: overflow %0b, expected %0b",
							result_count, overflow, want.ovf));
				end
			end
			if (in_valid && in_ready) begin
				if (mode == fpfir_pkg::MODE_COEFF) begin
					if (coeff_index < TAPS)
						tap_coeff[coeff_index] = coeff_value;
				end else begin
					filtered_q.push_back(filter_next_sample(sample_in));
				end
			end
			backlog = filtered_q.size();
		end
	end

endmodule

@@ bench/fixed_point_fir_filter_unit_tb.sv @@
`timescale 1ns / 100ps

module fixed_point_fir_filter_unit_tb;

	localparam int TAPS        = 32;
	localparam int ITEM_TARGET = 650;

	typedef enum {SC_RELOAD, SC_STREAM, SC_TWEAK, SC_NOISE} scenario_t;
	typedef enum {STYLE_FULL, STYLE_PEAK, STYLE_SMALL, STYLE_HELD} value_style_t;
	typedef enum {RX_OPEN, RX_COIN, RX_TRICKLE, RX_BLOCKED} rx_mode_t;

	logic                                   clk;
	logic                                   arst_n;
	logic                                   in_valid;
	logic                                   in_ready;
	logic                                   mode;
	logic signed [fpfir_pkg::SAMPLE_W-1:0]  sample_in;
	logic [fpfir_pkg::IDX_W-1:0]            coeff_index;
	logic signed [fpfir_pkg::COEFF_W-1:0]   coeff_value;
	logic                                   out_valid;
	logic                                   out_ready;
	logic signed [fpfir_pkg::OUT_W-1:0]     sample_out;
	logic                                   overflow;
	int unsigned                            failures;
	int unsigned                            pending;

	int                          items_sent;
	int                          burst_left;
	rx_mode_t                    rx_mode = RX_OPEN;
	int                          rx_left = 0;

	fixed_point_fir_filter_unit #(
		.TAPS(TAPS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.sample_in(sample_in),
		.coeff_index(coeff_index),
		.coeff_value(coeff_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sample_out(sample_out),
		.overflow(overflow)
	);

	fir_output_checker #(
		.TAPS(TAPS)
	) u_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.sample_in(sample_in),
		.coeff_index(coeff_index),
		.coeff_value(coeff_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sample_out(sample_out),
		.overflow(overflow),
		.failures(failures),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("fixed_point_fir_filter_unit_tb NOT OK");
		$finish;
	end

	// receiver: stretches of open, coin-toss, trickle and fully blocked
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			case (rx_mode)
				RX_OPEN:    rx_left = $urandom_range(20, 200);
				RX_COIN:    rx_left = $urandom_range(20, 100);
				RX_TRICKLE: rx_left = $urandom_range(20, 80);
				default:    rx_left = $urandom_range(10, 60);
			endcase
		end else begin
			rx_left--;
		end
		case (rx_mode)
			RX_OPEN:    out_ready <= 1'b1;
			RX_COIN:    out_ready <= 1'($urandom_range(0, 1));
			RX_TRICKLE: out_ready <= ($urandom_range(0, 7) == 0);
			default:    out_ready <= (rx_left == 0);
		endcase
	end

	// called at a falling edge, returns at a falling edge after the transfer
	task automatic send_item(input logic m, input logic signed [fpfir_pkg::SAMPLE_W-1:0] s,
			input logic [fpfir_pkg::IDX_W-1:0] idx,
			input logic signed [fpfir_pkg::COEFF_W-1:0] cv);
		int gap;
		int r;
		mode        <= m;
		sample_in   <= s;
		coeff_index <= idx;
		coeff_value <= cv;
		in_valid    <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
		items_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			in_valid <= 1'b0;
			r = $urandom_range(0, 9);
			if (r < 6)
				gap = $urandom_range(1, 4);
			else if (r < 9)
				gap = $urandom_range(5, 40);
			else
				gap = $urandom_range(41, 80);
			repeat (gap) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
				: $urandom_range(0, 6);
		end
	endtask

	// unused fields carry junk so their bits toggle too
	task automatic send_sample(input logic signed [fpfir_pkg::SAMPLE_W-1:0] s);
		send_item(fpfir_pkg::MODE_FILTER, s, fpfir_pkg::IDX_W'($urandom),
			fpfir_pkg::COEFF_W'($urandom));
	endtask

	task automatic send_coeff(input logic [fpfir_pkg::IDX_W-1:0] idx,
			input logic signed [fpfir_pkg::COEFF_W-1:0] cv);
		send_item(fpfir_pkg::MODE_COEFF, fpfir_pkg::SAMPLE_W'($urandom), idx, cv);
	endtask

	task automatic drain_results();
		if (in_valid)
			in_valid <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
	endtask

	function automatic logic signed [15:0] pick_value(input value_style_t st,
			input logic signed [15:0] held);
		case (st)
			STYLE_FULL:  return 16'($urandom);
			STYLE_SMALL: return 16'($urandom_range(0, 255)) - 16'sd128;
			STYLE_HELD:  return held;
			default: begin
				case ($urandom_range(0, 4))
					0:       return 16'sh7FFF;
					1:       return 16'sh8000;
					2:       return -16'sd1;
					3:       return 16'sd0;
					default: return 16'sd1;
				endcase
			end
		endcase
	endfunction

	initial begin
		scenario_t              kind;
		value_style_t           style;
		logic signed [15:0]     held;
		bit                     drained_mid;
		int                     r;

		arst_n      = 1'b0;
		in_valid    = 1'b0;
		mode        = fpfir_pkg::MODE_FILTER;
		sample_in   = '0;
		coeff_index = '0;
		coeff_value = '0;
		out_ready   = 1'b0;
		items_sent  = 0;
		burst_left  = 0;
		drained_mid = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// all-zero coefficients first, then extremes and alternating bit patterns
		send_sample(16'sh7FFF);
		send_coeff(5'd0, 16'sh7FFF);
		send_coeff(5'd1, 16'sh8000);
		send_coeff(5'd31, 16'sh8000);
		send_coeff(5'd2, 16'sd1);
		send_coeff(5'd3, -16'sd1);
		send_coeff(5'd30, 16'sh5555);
		send_coeff(5'd4, 16'shAAAA);
		send_sample(16'sh7FFF);
		send_sample(16'sh8000);
		send_sample(16'sd0);
		send_sample(-16'sd1);
		send_sample(16'sd15);
		send_sample(16'sd16);
		send_sample(-16'sd16);
		send_sample(-16'sd17);
		send_sample(16'sh5555);
		send_sample(16'shAAAA);
		send_coeff(5'd2, 16'sd0);
		send_sample(16'sh7FFF);
		send_sample(16'sh8000);
		send_sample(16'sh8000);
		send_sample(16'sh7FFF);
		drain_results();

		// full-scale taps against a full-scale input push the sum past the 16-bit output range
		held = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
		for (int i = 0; i < TAPS; i++)
			send_coeff(fpfir_pkg::IDX_W'(i), held);
		held = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
		repeat (40) send_sample(held);

		while (items_sent < ITEM_TARGET) begin
			if (!drained_mid && items_sent >= ITEM_TARGET / 2) begin
				drain_results();
				drained_mid = 1'b1;
			end
			r = $urandom_range(0, 19);
			if (r < 3)
				kind = SC_RELOAD;
			else if (r < 12)
				kind = SC_STREAM;
			else if (r < 16)
				kind = SC_TWEAK;
			else
				kind = SC_NOISE;
			style = value_style_t'($urandom_range(0, 3));
			held  = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
			case (kind)
				SC_RELOAD: begin
					for (int i = 0; i < TAPS; i++)
						send_coeff(fpfir_pkg::IDX_W'(i), pick_value(style, held));
				end
				SC_STREAM: begin
					repeat ($urandom_range(8, 48))
						send_sample(pick_value(style, held));
				end
				SC_TWEAK: begin
					repeat ($urandom_range(1, 4))
						send_coeff(fpfir_pkg::IDX_W'($urandom), pick_value(STYLE_FULL, held));
				end
				default: begin
					repeat ($urandom_range(4, 16))
						send_item($urandom_range(0, 1) ? fpfir_pkg::MODE_COEFF
							: fpfir_pkg::MODE_FILTER,
							fpfir_pkg::SAMPLE_W'($urandom), fpfir_pkg::IDX_W'($urandom),
							fpfir_pkg::COEFF_W'($urandom));
				end
			endcase
		end

		drain_results();
		repeat (TAPS + 8) @(negedge clk);
		if (failures == 0 && pending == 0)
			$display("fixed_point_fir_filter_unit_tb OK");
		else
			$display("fixed_point_fir_filter_unit_tb NOT OK");
		$finish;
	end

endmodule

@@ files.f @@
hw/rtl/fpfir_pkg.sv
hw/rtl/fpfir_cell.sv
hw/rtl/fixed_point_fir_filter_unit.sv
bench/fir_output_checker.sv
bench/fixed_point_fir_filter_unit_tb.sv
